// ----- hdl/combined_fibonacci_uniform_rng_unit_defines.svh -----
// Assertion macros for the combined Fibonacci uniform RNG unit.
// Used by the top level only; no other dependencies.
`ifndef COMBINED_FIBONACCI_UNIFORM_RNG_UNIT_DEFINES_SVH
`define COMBINED_FIBONACCI_UNIFORM_RNG_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CFRNG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFRNG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cfrng_pkg.sv -----
// Shared constants, command/status types and small arithmetic helpers
// for the combined Fibonacci uniform RNG. No dependencies.
`default_nettype none

package cfrng_pkg;

  localparam int LONG_LAG  = 17;
  localparam int SHORT_LAG = 5;
  localparam int WORD_BITS = 24;
  localparam int SEED_BITS = 32;
  localparam int IDX_BITS  = $clog2(LONG_LAG);

  localparam logic [WORD_BITS-1:0] C_INIT = 24'd362436;
  localparam logic [WORD_BITS-1:0] C_DEC  = 24'd7654321;
  localparam logic [WORD_BITS-1:0] C_MOD  = 24'd16777213;

  // Seed-mixing moduli
  localparam logic [7:0] MOD_I   = 8'd177;
  localparam logic [7:0] MOD_J   = 8'd167;
  localparam logic [7:0] MOD_K   = 8'd157;
  localparam logic [7:0] MOD_L   = 8'd147;
  localparam logic [7:0] MOD_M   = 8'd179;
  localparam logic [7:0] MOD_LCG = 8'd169;
  localparam logic [7:0] MUL_LCG = 8'd53;

  localparam logic [IDX_BITS-1:0] LONG_INIT  = IDX_BITS'(LONG_LAG - 1);
  localparam logic [IDX_BITS-1:0] SHORT_INIT = IDX_BITS'(SHORT_LAG - 1);
  localparam logic [IDX_BITS-1:0] LAST_WORD  = IDX_BITS'(LONG_LAG - 1);
  localparam logic [4:0]          LAST_BIT   = 5'(WORD_BITS - 1);
  // Seed magnitude is folded in one byte per step
  localparam logic [4:0]          LAST_MAG   = 5'(SEED_BITS / 8 - 1);

  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  typedef struct packed {
    logic                load_seed;
    logic                seed_sel;   // 1: item seed, 0: auto seed
    logic                mod_step;
    logic                mix_init;
    logic                mul1;
    logic                red1;
    logic                mul2;
    logic                red2;
    logic                shift_bit;
    logic                fill_wr;
    logic [IDX_BITS-1:0] fill_addr;
    logic                draw_rd;
    logic                draw_wr;
  } cfrng_cmd_t;

  typedef struct packed {
    logic out_free;
  } cfrng_stat_t;

  // x mod m by restoring subtraction; needs x < m * 256.
  function automatic logic [7:0] reduce_mod(input logic [15:0] x, input logic [7:0] m);
    logic [15:0] v;
    logic [15:0] d;
    v = x;
    for (int s = 7; s >= 0; s--) begin
      d = {8'd0, m} << s;
      if (v >= d) begin
        v = v - d;
      end
    end
    return v[7:0];
  endfunction

  function automatic logic [IDX_BITS-1:0] step_down(input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS-1:0] r;
    if (idx == '0 || idx > LAST_WORD) begin
      r = LAST_WORD;
    end else begin
      r = idx - IDX_BITS'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cfrng_datapath.sv -----
// Datapath: seed remainders, mixing sequence, lag table memory,
// congruential term and output register. Depends on cfrng_pkg.
`default_nettype none

module cfrng_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [cfrng_pkg::SEED_BITS-1:0]     cfg_data,
  input  wire logic [cfrng_pkg::SEED_BITS-1:0]     seed,
  input  wire cfrng_pkg::cfrng_cmd_t               cmd,
  output cfrng_pkg::cfrng_stat_t                   stat,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cfrng_pkg::WORD_BITS-1:0]          sample
);

  logic [cfrng_pkg::SEED_BITS-1:0] auto_seed;
  logic [cfrng_pkg::SEED_BITS-1:0] seed_src;
  logic [cfrng_pkg::SEED_BITS-1:0] mag_sh;
  logic [7:0] mag_top;
  logic [7:0] rem_i, rem_j, rem_k, rem_l;
  logic [7:0] i1, j1, k1, l1, r1, m1_new;
  logic [15:0] prod;
  logic [15:0] lcg_arg;
  logic [11:0] lm;
  logic [cfrng_pkg::WORD_BITS-1:0] word, fill_word;

  logic [cfrng_pkg::WORD_BITS-1:0] lag_mem [cfrng_pkg::LONG_LAG];
  logic [cfrng_pkg::WORD_BITS-1:0] rd_long, rd_short, t_val;
  logic [cfrng_pkg::IDX_BITS-1:0]  long_idx, short_idx;
  logic [cfrng_pkg::WORD_BITS-1:0] c_term, c_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_seed <= '0;
    end else if (cfg_we) begin
      auto_seed <= cfg_data;
    end
  end

  assign seed_src = cmd.seed_sel ? seed : auto_seed;
  assign mag_top  = mag_sh[cfrng_pkg::SEED_BITS-1 -: 8];

  // Seed magnitude, then four remainders one byte per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      mag_sh <= seed_src[cfrng_pkg::SEED_BITS-1] ? (~seed_src + 32'd1) : seed_src;
      rem_i  <= '0;
      rem_j  <= '0;
      rem_k  <= '0;
      rem_l  <= '0;
    end else if (cmd.mod_step) begin
      mag_sh <= {mag_sh[cfrng_pkg::SEED_BITS-9:0], 8'd0};
      rem_i  <= cfrng_pkg::reduce_mod({rem_i, mag_top}, cfrng_pkg::MOD_I);
      rem_j  <= cfrng_pkg::reduce_mod({rem_j, mag_top}, cfrng_pkg::MOD_J);
      rem_k  <= cfrng_pkg::reduce_mod({rem_k, mag_top}, cfrng_pkg::MOD_K);
      rem_l  <= cfrng_pkg::reduce_mod({rem_l, mag_top}, cfrng_pkg::MOD_L);
    end
  end

  // Mixing sequence: multiply, reduce, multiply, reduce, then shift in a bit
  assign m1_new  = cfrng_pkg::reduce_mod(prod, cfrng_pkg::MOD_M);
  assign lcg_arg = 16'(l1) * 16'(cfrng_pkg::MUL_LCG) + 16'd1;
  assign lm      = 12'(l1[5:0]) * 12'(k1[5:0]);
  assign fill_word = {word[cfrng_pkg::WORD_BITS-2:0], lm[5]};

  always_ff @(posedge clk) begin
    if (cmd.mix_init) begin
      i1   <= rem_i + 8'd1;
      j1   <= rem_j + 8'd1;
      k1   <= rem_k + 8'd1;
      l1   <= rem_l + 8'd1;
      word <= '0;
    end else begin
      if (cmd.mul1) begin
        prod <= 16'(i1) * 16'(j1);
      end
      if (cmd.red1) begin
        r1 <= cfrng_pkg::reduce_mod(prod, cfrng_pkg::MOD_M);
      end
      if (cmd.mul2) begin
        prod <= 16'(r1) * 16'(k1);
      end
      if (cmd.red2) begin
        i1 <= j1;
        j1 <= k1;
        k1 <= m1_new;
        l1 <= cfrng_pkg::reduce_mod(lcg_arg, cfrng_pkg::MOD_LCG);
      end
      if (cmd.shift_bit) begin
        word <= fill_word;
      end
    end
  end

  // Lag table: one write port, two registered read ports
  assign t_val = rd_long - rd_short;

  always_ff @(posedge clk) begin
    if (cmd.draw_wr) begin
      lag_mem[long_idx] <= t_val;
    end else if (cmd.fill_wr) begin
      lag_mem[cmd.fill_addr] <= fill_word;
    end
    if (cmd.draw_rd) begin
      rd_long  <= lag_mem[long_idx];
      rd_short <= lag_mem[short_idx];
    end
  end

  assign c_next = (c_term >= cfrng_pkg::C_DEC) ? (c_term - cfrng_pkg::C_DEC)
                                               : (c_term + (cfrng_pkg::C_MOD - cfrng_pkg::C_DEC));

  always_ff @(posedge clk) begin
    if (rst) begin
      long_idx  <= cfrng_pkg::LONG_INIT;
      short_idx <= cfrng_pkg::SHORT_INIT;
      c_term    <= cfrng_pkg::C_INIT;
    end else begin
      if (cmd.draw_rd) begin
        c_term <= c_next;
      end
      if (cmd.draw_wr) begin
        long_idx  <= cfrng_pkg::step_down(long_idx);
        short_idx <= cfrng_pkg::step_down(short_idx);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.draw_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_wr) begin
      sample <= t_val - c_term;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hdl/cfrng_ctrl.sv -----
// Controller FSM: sequences seeding (remainders, mixing, table fill)
// and draws. Depends on cfrng_pkg.
`default_nettype none

module cfrng_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  func,
  input  wire cfrng_pkg::cfrng_stat_t stat,
  output cfrng_pkg::cfrng_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_MODS    = 9'b000000010,
    S_MIX     = 9'b000000100,
    S_MUL1    = 9'b000001000,
    S_RED1    = 9'b000010000,
    S_MUL2    = 9'b000100000,
    S_RED2    = 9'b001000000,
    S_SHIFT   = 9'b010000000,
    S_DRAW_RD = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [cfrng_pkg::IDX_BITS-1:0] word_idx, word_idx_next;
  logic seeded, seeded_next;
  logic pend_draw, pend_draw_next;
  logic draw_wr_pend, draw_wr_pend_next;
  logic accept;

  assign in_ready = (state == S_IDLE) && !draw_wr_pend;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    word_idx_next     = word_idx;
    seeded_next       = seeded;
    pend_draw_next    = pend_draw;
    draw_wr_pend_next = draw_wr_pend;
    cmd               = '0;
    cmd.fill_addr     = word_idx;

    // draw write-back waits for a free output slot
    if (draw_wr_pend && stat.out_free) begin
      cmd.draw_wr       = 1'b1;
      draw_wr_pend_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_seed  = 1'b1;
          cmd.seed_sel   = (func == cfrng_pkg::FUNC_RESEED);
          pend_draw_next = (func == cfrng_pkg::FUNC_DRAW);
          cnt_next       = '0;
          if (func == cfrng_pkg::FUNC_RESEED || !seeded) begin
            state_next = S_MODS;
          end else begin
            state_next = S_DRAW_RD;
          end
        end
      end
      S_MODS: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == cfrng_pkg::LAST_MAG) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix_init  = 1'b1;
        cnt_next      = '0;
        word_idx_next = '0;
        state_next    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_RED1;
      end
      S_RED1: begin
        cmd.red1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_RED2;
      end
      S_RED2: begin
        cmd.red2   = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_bit = 1'b1;
        state_next    = S_MUL1;
        if (cnt == cfrng_pkg::LAST_BIT) begin
          cmd.fill_wr = 1'b1;
          cnt_next    = '0;
          if (word_idx == cfrng_pkg::LAST_WORD) begin
            seeded_next = 1'b1;
            state_next  = pend_draw ? S_DRAW_RD : S_IDLE;
          end else begin
            word_idx_next = word_idx + cfrng_pkg::IDX_BITS'(1);
          end
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DRAW_RD: begin
        cmd.draw_rd       = 1'b1;
        draw_wr_pend_next = 1'b1;
        pend_draw_next    = 1'b0;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      word_idx     <= '0;
      seeded       <= 1'b0;
      pend_draw    <= 1'b0;
      draw_wr_pend <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      word_idx     <= word_idx_next;
      seeded       <= seeded_next;
      pend_draw    <= pend_draw_next;
      draw_wr_pend <= draw_wr_pend_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/combined_fibonacci_uniform_rng_unit.sv -----
// Combined lagged-Fibonacci / congruential uniform RNG, top level.
// Depends on cfrng_pkg, cfrng_ctrl, cfrng_datapath and the defines header.
//
// Usage:
//  - Input channel (in_valid/in_ready, func, seed): func = draw produces one
//    sample transaction; func = reseed refills the 17-word lag table from
//    seed and produces nothing.
//  - Output channel (out_valid/out_ready, sample): 24-bit unsigned fraction.
//  - cfg_we/cfg_data write auto_seed; write only while the unit is idle.
// Sequencing:
//  - Seeded draw: accept, table read, then write-back into the output register
//    once the slot frees, before the next accept; sample visible the cycle after.
//  - Reseed: 4 remainder steps of one seed byte each, mixing setup, then 408 table
//    bits, each by multiply, reduce, multiply, reduce, shift on the shared unit.
//  - A draw before any seeding first runs the same fill from auto_seed.
// Reset (rst, synchronous): indices 16/4, congruential term 362436,
// auto_seed 0, unseeded. Table content is not cleared.
// Stall: the output register holds a finished sample while the unit takes
// the next transaction; a draw's write-back waits until the slot frees.
`default_nettype none

`include "combined_fibonacci_uniform_rng_unit_defines.svh"

module combined_fibonacci_uniform_rng_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [cfrng_pkg::SEED_BITS-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic [cfrng_pkg::SEED_BITS-1:0] seed,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [cfrng_pkg::WORD_BITS-1:0]      sample
);

  cfrng_pkg::cfrng_cmd_t  cmd;
  cfrng_pkg::cfrng_stat_t stat;

  // Sequencer: owns seeding progress and draw ordering
  cfrng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, lag table and output register
  cfrng_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .seed      (seed),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
  );

  // Busy right after taking a transaction
  `CFRNG_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  // Write-back never overwrites a pending sample
  `CFRNG_ASSERT_IMP(a_wr_into_free, clk, rst, cmd.draw_wr, stat.out_free, "output overwritten")
  // Mixing phases are exclusive
  `CFRNG_ASSERT_IMP(a_phase_excl, clk, rst, 1'b1, $onehot0({cmd.mul1, cmd.red1, cmd.mul2, cmd.red2, cmd.shift_bit, cmd.mod_step, cmd.draw_rd}), "phase overlap")
  // Table fill only with a completed bit
  `CFRNG_ASSERT_IMP(a_fill_on_shift, clk, rst, cmd.fill_wr, cmd.shift_bit && !cmd.draw_wr, "fill outside shift")

endmodule

`default_nettype wire
